### rtl/core/rea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocatable expression ALU package
// Shared request and response types, operation codes and the lane record
// that moves along the division chain.
// ----------------------------------------------------------------------------
package rea_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned SegW  = 3;
    localparam int unsigned OpW   = 5;

    localparam logic [OpW-1:0] OP_ADD    = 5'd0;
    localparam logic [OpW-1:0] OP_SUB    = 5'd1;
    localparam logic [OpW-1:0] OP_MUL    = 5'd2;
    localparam logic [OpW-1:0] OP_DIV    = 5'd3;
    localparam logic [OpW-1:0] OP_MOD    = 5'd4;
    localparam logic [OpW-1:0] OP_SHL    = 5'd5;
    localparam logic [OpW-1:0] OP_SHR    = 5'd6;
    localparam logic [OpW-1:0] OP_AND    = 5'd7;
    localparam logic [OpW-1:0] OP_OR     = 5'd8;
    localparam logic [OpW-1:0] OP_XOR    = 5'd9;
    localparam logic [OpW-1:0] OP_EQ     = 5'd10;
    localparam logic [OpW-1:0] OP_NE     = 5'd11;
    localparam logic [OpW-1:0] OP_LT     = 5'd12;
    localparam logic [OpW-1:0] OP_LE     = 5'd13;
    localparam logic [OpW-1:0] OP_GT     = 5'd14;
    localparam logic [OpW-1:0] OP_GE     = 5'd15;
    localparam logic [OpW-1:0] OP_NOT    = 5'd16;
    localparam logic [OpW-1:0] OP_HIGH   = 5'd17;
    localparam logic [OpW-1:0] OP_LOW    = 5'd18;
    localparam logic [OpW-1:0] OP_UPLUS  = 5'd19;
    localparam logic [OpW-1:0] OP_UMINUS = 5'd20;
    localparam logic [OpW-1:0] OP_NUL    = 5'd21;
    localparam logic [OpW-1:0] OP_TYPE   = 5'd22;

    localparam logic [DataW-1:0] ALL_ONES = 16'hFFFF;
    localparam logic [3:0]       SHIFT_MASK = 4'hF;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [DataW-1:0] left_value;
        logic [SegW-1:0]  left_segment;
        logic             left_external;
        logic [DataW-1:0] right_value;
        logic [SegW-1:0]  right_segment;
    } t_req;

    typedef struct packed {
        logic [DataW-1:0] result_value;
        logic [SegW-1:0]  result_segment;
        logic             result_external;
        logic             reloc_error;
        logic             divide_zero_error;
        logic             bad_op_error;
    } t_rsp;

    // Which value the end of the chain delivers.
    typedef enum logic [1:0] {
        K_PLAIN = 2'b00,
        K_DIV   = 2'b01,
        K_MOD   = 2'b10
    } t_kind;

    // One request in flight: the finished response for all operations but
    // div and mod, plus the partial remainder, quotient and divisor.
    typedef struct packed {
        t_rsp             rsp;
        t_kind            kind;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;
        logic [DataW-1:0] dvs;
    } t_lane;

endpackage

### rtl/core/rea_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocatable expression ALU front cell
// Decodes the operation, computes every result except div and mod, applies
// the relocation rules and loads the first lane of the division chain.
// ----------------------------------------------------------------------------
module rea_front import rea_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_req  i_req,
    output logic  o_valid,
    output t_lane o_lane
);

    logic             r_valid;
    t_lane            r_lane;
    t_lane            n_lane;
    logic [31:0]      w_prod;
    logic             w_any_rel;
    logic             w_la;
    logic             w_lb;
    logic [DataW-1:0] w_a;
    logic [DataW-1:0] w_b;

    assign w_a       = i_req.left_value;
    assign w_b       = i_req.right_value;
    assign w_la      = (i_req.left_segment != '0);
    assign w_lb      = (i_req.right_segment != '0);
    assign w_any_rel = w_la || w_lb;
    assign w_prod    = w_a * w_b;

    always_comb begin
        n_lane     = '0;
        n_lane.rsp = '0;
        n_lane.kind = K_PLAIN;
        n_lane.rem = '0;
        n_lane.quo = w_a;
        n_lane.dvs = w_b;
        case (i_req.op)
            OP_ADD: begin
                n_lane.rsp.result_value = w_a + w_b;
                if (w_la && w_lb) begin
                    n_lane.rsp.reloc_error = 1'b1;
                end else begin
                    n_lane.rsp.result_segment = w_la ? i_req.left_segment
                                                     : i_req.right_segment;
                end
            end
            OP_SUB: begin
                n_lane.rsp.result_value = w_a - w_b;
                if (i_req.left_segment == i_req.right_segment) begin
                    n_lane.rsp.result_segment = '0;
                end else if (w_lb) begin
                    n_lane.rsp.reloc_error = 1'b1;
                end else begin
                    n_lane.rsp.result_segment = i_req.left_segment;
                end
            end
            OP_MUL: begin
                n_lane.rsp.reloc_error  = w_any_rel;
                n_lane.rsp.result_value = w_prod[DataW-1:0];
            end
            OP_DIV: begin
                n_lane.rsp.reloc_error       = w_any_rel;
                n_lane.rsp.divide_zero_error = (w_b == '0);
                n_lane.kind                  = K_DIV;
            end
            OP_MOD: begin
                n_lane.rsp.reloc_error       = w_any_rel;
                n_lane.rsp.divide_zero_error = (w_b == '0);
                n_lane.kind                  = K_MOD;
            end
            OP_SHL: begin
                n_lane.rsp.reloc_error  = w_any_rel;
                n_lane.rsp.result_value = w_a << (w_b[3:0] & SHIFT_MASK);
            end
            OP_SHR: begin
                n_lane.rsp.reloc_error  = w_any_rel;
                n_lane.rsp.result_value = w_a >> (w_b[3:0] & SHIFT_MASK);
            end
            OP_AND: begin
                n_lane.rsp.reloc_error  = w_any_rel;
                n_lane.rsp.result_value = w_a & w_b;
            end
            OP_OR: begin
                n_lane.rsp.reloc_error  = w_any_rel;
                n_lane.rsp.result_value = w_a | w_b;
            end
            OP_XOR: begin
                n_lane.rsp.reloc_error  = w_any_rel;
                n_lane.rsp.result_value = w_a ^ w_b;
            end
            OP_EQ: begin
                n_lane.rsp.result_value = (w_a == w_b) ? ALL_ONES : '0;
            end
            OP_NE: begin
                n_lane.rsp.result_value = (w_a != w_b) ? ALL_ONES : '0;
            end
            OP_LT: begin
                n_lane.rsp.result_value = ($signed(w_a) < $signed(w_b)) ? ALL_ONES : '0;
            end
            OP_LE: begin
                n_lane.rsp.result_value = ($signed(w_a) <= $signed(w_b)) ? ALL_ONES : '0;
            end
            OP_GT: begin
                n_lane.rsp.result_value = ($signed(w_a) > $signed(w_b)) ? ALL_ONES : '0;
            end
            OP_GE: begin
                n_lane.rsp.result_value = ($signed(w_a) >= $signed(w_b)) ? ALL_ONES : '0;
            end
            OP_NOT: begin
                n_lane.rsp.reloc_error  = w_la;
                n_lane.rsp.result_value = ~w_a;
            end
            OP_HIGH: begin
                n_lane.rsp.reloc_error  = w_la;
                n_lane.rsp.result_value = {8'h00, w_a[15:8]};
            end
            OP_LOW: begin
                n_lane.rsp.reloc_error  = w_la;
                n_lane.rsp.result_value = {8'h00, w_a[7:0]};
            end
            OP_UPLUS: begin
                n_lane.rsp.result_value    = w_a;
                n_lane.rsp.result_segment  = i_req.left_segment;
                n_lane.rsp.result_external = i_req.left_external;
            end
            OP_UMINUS: begin
                n_lane.rsp.reloc_error  = w_la;
                n_lane.rsp.result_value = DataW'(0) - w_a;
            end
            OP_NUL, OP_TYPE: begin
                n_lane.rsp.result_value = w_a;
            end
            default: begin
                n_lane.rsp.bad_op_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

### rtl/core/rea_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocatable expression ALU division cell
// One restoring division step: shifts in the next dividend bit, trials a
// subtract of the divisor and hands the lane to the next cell.
// ----------------------------------------------------------------------------
module rea_div_cell import rea_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    logic             r_valid;
    t_lane            r_lane;
    t_lane            n_lane;
    logic [DataW:0]   w_shift;
    logic [DataW:0]   w_trial;
    logic             w_fits;

    // The remainder stays below the divisor, so the shifted value fits in
    // one extra bit and the trial's top bit is the borrow.
    assign w_shift = {i_lane.rem, i_lane.quo[DataW-1]};
    assign w_trial = w_shift - {1'b0, i_lane.dvs};
    assign w_fits  = ~w_trial[DataW];

    always_comb begin
        n_lane     = i_lane;
        n_lane.rem = w_fits ? w_trial[DataW-1:0] : w_shift[DataW-1:0];
        n_lane.quo = {i_lane.quo[DataW-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

### rtl/core/relocatable_expression_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocatable expression ALU
// Evaluates one operator of a 16-bit assembler expression with relocation
// tracking, one request per clock while o_stall is low, through a chain of division cells.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Handshake          Payload
//  request    in         i_valid / o_stall  i_req (t_req)
//  response   out        o_valid / i_stall  o_rsp (t_rsp)
//
// A new request is taken in every cycle while o_stall is low; each one passes
// from acceptance through the front cell register, the sixteen division cells,
// one per quotient bit, and the output register to its response.
// Reset clears every valid bit in the chain and the output stage only.
// A stalled response waits in the output register; a one-entry skid register
// catches the next one, and only while it is full does the chain freeze and o_stall rise.
//
module relocatable_expression_alu_top import rea_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    // The chain advances as a whole whenever the skid register is empty.
    logic  w_en;
    logic  w_vld [0:DataW];
    t_lane w_lane [0:DataW];
    t_rsp  w_done;
    logic  w_arrive;
    logic  w_take;

    logic  r_out_valid;
    logic  n_out_valid;
    logic  r_skid_valid;
    logic  n_skid_valid;
    t_rsp  r_out;
    t_rsp  n_out;
    t_rsp  r_skid;
    t_rsp  n_skid;

    assign w_en = ~r_skid_valid;

    rea_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (w_vld[0]),
        .o_lane  (w_lane[0])
    );

    // Sixteen cells, each resolving one quotient bit from the top down.
    for (genvar g = 0; g < DataW; g++) begin : g_cell
        rea_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_vld[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // Pick the quotient or remainder at the end of the chain. A zero divisor
    // forces the value to zero; the flag was already set by the front cell.
    always_comb begin
        w_done = w_lane[DataW].rsp;
        case (w_lane[DataW].kind)
            K_DIV: begin
                w_done.result_value = w_lane[DataW].rsp.divide_zero_error
                                      ? '0 : w_lane[DataW].quo;
            end
            K_MOD: begin
                w_done.result_value = w_lane[DataW].rsp.divide_zero_error
                                      ? '0 : w_lane[DataW].rem;
            end
            default: begin
                w_done.result_value = w_lane[DataW].rsp.result_value;
            end
        endcase
    end

    assign w_arrive = w_en && w_vld[DataW];
    assign w_take   = r_out_valid && !i_stall;

    // Output register plus skid entry. A response leaving the chain goes to
    // the output register when it is free or being emptied, else to the skid.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_valid || w_take) begin
                n_out       = w_done;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_done;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;
    assign o_stall = r_skid_valid;

    // The skid entry only fills behind a held response.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register is empty");

    // A full skid entry freezes the chain for that cycle.
    a_chain_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(w_vld[DataW]))
        else $error("division chain moved while skid entry was full");

    // A zero divisor always yields a zero value.
    a_div_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.divide_zero_error) |-> (o_rsp.result_value == '0))
        else $error("divide by zero produced a nonzero value");

    // An invalid operation carries nothing but its flag.
    a_bad_op_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.bad_op_error) |->
            (o_rsp.result_value == '0 && o_rsp.result_segment == '0 &&
             !o_rsp.reloc_error && !o_rsp.divide_zero_error &&
             !o_rsp.result_external))
        else $error("invalid operation produced a nonzero response");

endmodule
